### src/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

### src/sefr_pkg.sv
package sefr_pkg;

  // Default sizes of the frame store.
  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int STORE_DEPTH_DEF = 66;

  // Fixed field widths.
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Framing characters.
  localparam logic [BYTE_W-1:0] BYTE_STX = 8'h02;
  localparam logic [BYTE_W-1:0] BYTE_ETX = 8'h03;
  localparam logic [BYTE_W-1:0] BYTE_DLE = 8'h10;

  // CRC-CCITT-FALSE.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_NIBBLE  = 2'd1;

  localparam logic [3:0] EVENT_NIBBLE_RST = 4'hE;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BADSUM      = 3'd2,
    ST_EARLY_START = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_WAIT,
    S_DATA,
    S_ESC,
    S_SUM,
    S_CHECK,
    S_EMIT
  } state_t;

  // One byte of CRC-CCITT, MSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/sefr_if.sv
// Received byte channel.
interface sefr_rx_if import sefr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface sefr_res_if import sefr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   payload_byte;
  logic [STATUS_W-1:0] status;
  logic                is_event;
  logic                last;

  modport source (output valid, output payload_byte, output status, output is_event,
                  output last, input ready);
  modport sink (input valid, input payload_byte, input status, input is_event,
                input last, output ready);
endinterface

// Configuration write channel.
interface sefr_cfg_if import sefr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/stx_etx_frame_receiver.sv
// STX/ETX frame receiver with DLE byte stuffing. Each rx beat carries one byte from the
// serial line; bytes outside a frame are dropped until STX. Frame bytes, with DLE
// escapes removed, are written into a single-port frame store of STORE_DEPTH bytes. On
// ETX the store is swept once to form the checksum (one byte per cycle through the one
// read port), then, for a good frame, swept again to emit one result beat per payload
// byte, the last one flagged with last, and with is_event when the high nibble of the
// first payload byte matches the event nibble. rx is held off until the frame end is
// handled. A short frame, a bad checksum, an STX inside a frame or an overlong frame
// gives a single status beat and the receiver goes back to waiting for STX. The store
// needs no clearing after reset. Configuration (checksum mode at index 0, event nibble
// at index 1) must be written only while the receiver is idle; the block itself does
// not enforce this.
module stx_etx_frame_receiver import sefr_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  sefr_rx_if.sink    rx,
  sefr_res_if.source res,
  sefr_cfg_if.sink   cfg
);

`include "assert_macros.svh"

  // Address width of the store, and count width that can also hold the depth itself.
  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  // Configuration registers.
  logic       checksum_mode;
  logic [3:0] event_nibble;

  // Control state.
  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;           // bytes stored in the current frame
  logic [CNT_W-1:0] rd_ptr, rd_ptr_next;     // next store address to read
  logic [CNT_W-1:0] proc_idx, proc_idx_next; // index of the byte in mem_rdata
  logic             rd_valid;                // mem_rdata holds a byte of the sweep

  // Checksum accumulators.
  logic [15:0] crc, crc_next;
  logic [7:0]  sum, sum_next;
  logic [15:0] cmp, cmp_next;                // the trailing checksum bytes
  logic [3:0]  first_hi, first_hi_next;      // high nibble of the first payload byte

  // Frame store.
  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] mem_rdata;

  // Output register.
  logic                out_valid;
  logic [BYTE_W-1:0]   out_byte, out_byte_next;
  logic [STATUS_W-1:0] out_status, out_status_next;
  logic                out_event, out_event_next;
  logic                out_last, out_last_next;
  logic                out_load;

  logic             slot_free;
  logic             rx_ready;
  logic             rx_fire;
  logic [CNT_W-1:0] cklen;
  logic [CNT_W-1:0] plen;
  logic [CNT_W-1:0] rd_ptr_inc;
  logic             good;
  logic             emit_last;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_mode <= 1'b0;
      event_nibble  <= EVENT_NIBBLE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CHECKSUM_MODE: checksum_mode <= cfg.data[0];
        REG_EVENT_NIBBLE:  event_nibble  <= cfg.data[3:0];
        default: begin
        end
      endcase
    end
  end

  // The store is written only while bytes arrive and read only during the two sweeps,
  // so a read never meets a write to the same entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_rdata <= mem[rd_addr];
    end
  end

  // The result channel is decoupled by the output register; rx stays open in the idle
  // state, and inside a frame whenever a status beat could still be placed.
  assign slot_free  = !out_valid || res.ready;
  assign rx_ready   = (state == S_WAIT) || ((state == S_DATA || state == S_ESC) && slot_free);
  assign rx.ready   = rx_ready;
  assign rx_fire    = rx.valid && rx_ready;
  assign cklen      = checksum_mode ? CNT_W'(2) : CNT_W'(1);
  assign plen       = cnt - cklen;
  assign rd_ptr_inc = rd_ptr + 1'b1;
  assign good       = checksum_mode ? (cmp == crc) : (cmp[7:0] == 8'(8'd0 - sum));
  assign emit_last  = (rd_ptr == plen - 1'b1);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    rd_ptr_next     = rd_ptr;
    proc_idx_next   = proc_idx;
    crc_next        = crc;
    sum_next        = sum;
    cmp_next        = cmp;
    first_hi_next   = first_hi;
    mem_we          = 1'b0;
    mem_waddr       = cnt[AW-1:0];
    mem_wdata       = rx.rx_byte;
    rd_en           = 1'b0;
    rd_addr         = rd_ptr[AW-1:0];
    out_load        = 1'b0;
    out_byte_next   = '0;
    out_status_next = ST_OK;
    out_event_next  = 1'b0;
    out_last_next   = 1'b1;

    unique case (state)
      S_WAIT: begin
        if (rx_fire) begin
          cnt_next = '0;
          if (rx.rx_byte == BYTE_STX) begin
            state_next = S_DATA;
          end
        end
      end

      S_DATA, S_ESC: begin
        if (rx_fire) begin
          if (state == S_DATA && rx.rx_byte == BYTE_ETX) begin
            if (cnt <= cklen) begin
              out_load        = 1'b1;
              out_status_next = ST_SHORT;
              cnt_next        = '0;
              state_next      = S_WAIT;
            end else begin
              rd_ptr_next   = '0;
              proc_idx_next = '0;
              crc_next      = CRC_INIT;
              sum_next      = '0;
              state_next    = S_SUM;
            end
          end else if (state == S_DATA && rx.rx_byte == BYTE_STX) begin
            out_load        = 1'b1;
            out_status_next = ST_EARLY_START;
            cnt_next        = '0;
            state_next      = S_WAIT;
          end else if (state == S_DATA && rx.rx_byte == BYTE_DLE) begin
            state_next = S_ESC;
          end else begin
            // Plain byte, or any byte after an escape.
            mem_we = 1'b1;
            if (cnt == CNT_W'(STORE_DEPTH - 1)) begin
              out_load        = 1'b1;
              out_status_next = ST_TOO_LONG;
              cnt_next        = '0;
              state_next      = S_WAIT;
            end else begin
              cnt_next   = cnt + 1'b1;
              state_next = S_DATA;
            end
          end
        end
      end

      S_SUM: begin
        // Reads run ahead of the accumulation: each byte read is registered and accumulated in the next cycle.
        if (rd_ptr < cnt) begin
          rd_en       = 1'b1;
          rd_ptr_next = rd_ptr_inc;
        end
        if (rd_valid) begin
          if (proc_idx == '0) begin
            first_hi_next = mem_rdata[7:4];
          end
          if (proc_idx < plen) begin
            crc_next = crc_step(crc, mem_rdata);
            sum_next = sum + mem_rdata;
          end else begin
            cmp_next = {cmp[7:0], mem_rdata};
          end
          proc_idx_next = proc_idx + 1'b1;
          if (proc_idx == cnt - 1'b1) begin
            state_next = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if (slot_free) begin
          if (!good) begin
            out_load        = 1'b1;
            out_status_next = ST_BADSUM;
            cnt_next        = '0;
            state_next      = S_WAIT;
          end else if (int'(plen) > MAX_PAYLOAD) begin
            out_load        = 1'b1;
            out_status_next = ST_TOO_LONG;
            cnt_next        = '0;
            state_next      = S_WAIT;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = '0;
            rd_ptr_next = '0;
            state_next  = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        // mem_rdata holds payload byte rd_ptr until it moves into the output register.
        if (slot_free) begin
          out_load       = 1'b1;
          out_byte_next  = mem_rdata;
          out_last_next  = emit_last;
          out_event_next = emit_last && (first_hi == event_nibble);
          if (emit_last) begin
            cnt_next   = '0;
            state_next = S_WAIT;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = rd_ptr_inc[AW-1:0];
            rd_ptr_next = rd_ptr_inc;
          end
        end
      end

      default: begin
        state_next = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT;
      cnt       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      rd_valid <= rd_en && (state == S_SUM);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr   <= rd_ptr_next;
    proc_idx <= proc_idx_next;
    crc      <= crc_next;
    sum      <= sum_next;
    cmp      <= cmp_next;
    first_hi <= first_hi_next;
    if (out_load) begin
      out_byte   <= out_byte_next;
      out_status <= out_status_next;
      out_event  <= out_event_next;
      out_last   <= out_last_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.payload_byte = out_byte;
  assign res.status       = out_status;
  assign res.is_event     = out_event;
  assign res.last         = out_last;

  // A waiting result is never overwritten.
  `ASSERT_NEVER(a_no_overwrite, clk, rst, out_load && out_valid && !res.ready)
  // The stored count stays inside the store.
  `ASSERT_PROP(a_cnt_range, clk, rst, cnt < CNT_W'(STORE_DEPTH))
  // The final beat of a frame always returns the receiver to waiting for STX.
  `ASSERT_PROP(a_last_to_wait, clk, rst, (out_load && out_last_next) |=> (state == S_WAIT))
  // The checksum sweep never reads beyond the stored bytes.
  `ASSERT_PROP(a_sweep_bound, clk, rst, (state == S_SUM) |-> (rd_ptr <= cnt))

endmodule
